// ===== rtl/core/mdi_pkg.sv =====
package mdi_pkg;

    localparam int unsigned ELEM_W = 16;
    localparam int unsigned COF_W  = 2 * ELEM_W + 1;
    localparam int unsigned DET_W  = 3 * ELEM_W + 1;
    localparam int unsigned NUM_W  = COF_W + ELEM_W;
    localparam int unsigned DSH_W  = DET_W + ELEM_W - 1;
    localparam int unsigned REM_W  = DSH_W + 1;
    localparam int unsigned QUO_W  = ELEM_W;
    localparam int unsigned STEPS  = QUO_W;

    localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

    // Operand indexes of the eighteen 2x2 products: cof[k] = A[2k]*B[2k] - A[2k+1]*B[2k+1].
    localparam int unsigned PROD_A [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2,
                                            1, 0, 1, 2, 2, 0, 0, 1};
    localparam int unsigned PROD_B [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6,
                                            6, 7, 5, 4, 3, 5, 4, 3};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [8:0]             lane;
        logic [DSH_W-1:0]        dsh;
        logic signed [DET_W-1:0] det;
        logic                    sing;
    } div_t;

endpackage

// ===== rtl/core/matrix3_determinant_inverse.sv =====
// Five cofactor and determinant stages, sixteen one-bit divider stages, one saturation stage.
// Throughput: one matrix per cycle; each stage holds only while its successor is full.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers keep their value.
module matrix3_determinant_inverse
    import mdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // elem_0 .. elem_8, 16 bits each from bit 0
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // inv_0 .. inv_8 (16 bits each), determinant (49), zero pad
    output logic [1:0]   m_tuser    // singular, saturated
);

    logic        v   [STEPS+1];
    logic        rdy [STEPS+1];
    div_t        d   [STEPS+1];

    mdi_cofdet u_cofdet (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (v[0]),
        .out_ready (rdy[0]),
        .out_data  (d[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        mdi_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[i]),
            .in_ready  (rdy[i]),
            .in_data   (d[i]),
            .out_valid (v[i+1]),
            .out_ready (rdy[i+1]),
            .out_data  (d[i+1])
        );
    end

    mdi_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v[STEPS]),
        .in_ready  (rdy[STEPS]),
        .in_data   (d[STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

// ===== rtl/core/mdi_cofdet.sv =====
module mdi_cofdet
    import mdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [143:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output div_t         out_data
);

    logic signed [ELEM_W-1:0] m [9];
    logic [4:0] vld_reg;
    logic [4:0] en;

    logic signed [ELEM_W-1:0]   m1_reg  [3];
    logic signed [2*ELEM_W-1:0] p1_reg  [18];
    logic signed [ELEM_W-1:0]   m2_reg  [3];
    logic signed [COF_W-1:0]    c2_reg  [9];
    logic signed [DET_W-1:0]    t3_reg  [3];
    logic signed [COF_W-1:0]    c3_reg  [9];
    logic signed [DET_W-1:0]    d4_reg;
    logic signed [COF_W-1:0]    c4_reg  [9];
    div_t                       s5_reg;
    div_t                       s5_next;
    logic [DET_W-1:0]           dabs;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m[k] = in_data[k*ELEM_W +: ELEM_W];
        end
    end

    // A stage moves when it is empty or its successor moves.
    assign en[4] = !vld_reg[4] || out_ready;
    assign en[3] = !vld_reg[3] || en[4];
    assign en[2] = !vld_reg[2] || en[3];
    assign en[1] = !vld_reg[1] || en[2];
    assign en[0] = !vld_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = vld_reg[4];
    assign out_data  = s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int s = 1; s < 5; s++)
            begin
                if (en[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_comb
    begin
        dabs = d4_reg[DET_W-1] ? DET_W'(-d4_reg) : DET_W'(d4_reg);
        s5_next.det  = d4_reg;
        s5_next.sing = (d4_reg == '0);
        s5_next.dsh  = {dabs, {(ELEM_W-1){1'b0}}};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic signed [COF_W-1:0] cf;
                logic [COF_W-1:0]        cabs;
                cf   = c4_reg[c*3+r];
                cabs = cf[COF_W-1] ? COF_W'(-cf) : COF_W'(cf);
                s5_next.lane[r*3+c].rem = REM_W'({cabs, {ELEM_W{1'b0}}});
                s5_next.lane[r*3+c].quo = '0;
                s5_next.lane[r*3+c].neg = cf[COF_W-1] ^ d4_reg[DET_W-1];
                // A quotient of 2^16 or more is caught here and saturates later.
                s5_next.lane[r*3+c].ovf = (DET_W'(cabs) >= dabs);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++) m1_reg[k] <= m[k];
            for (int j = 0; j < 18; j++) p1_reg[j] <= m[PROD_A[j]] * m[PROD_B[j]];
        end
        if (en[1])
        begin
            for (int k = 0; k < 3; k++) m2_reg[k] <= m1_reg[k];
            for (int k = 0; k < 9; k++)
            begin
                c2_reg[k] <= COF_W'(p1_reg[2*k]) - COF_W'(p1_reg[2*k+1]);
            end
        end
        if (en[2])
        begin
            // First-row expansion equals the six-term rule.
            for (int k = 0; k < 3; k++) t3_reg[k] <= m2_reg[k] * c2_reg[k];
            for (int k = 0; k < 9; k++) c3_reg[k] <= c2_reg[k];
        end
        if (en[3])
        begin
            d4_reg <= t3_reg[0] + t3_reg[1] + t3_reg[2];
            for (int k = 0; k < 9; k++) c4_reg[k] <= c3_reg[k];
        end
        if (en[4])
        begin
            s5_reg <= s5_next;
        end
    end

endmodule

// ===== rtl/core/mdi_div_step.sv =====
module mdi_div_step
    import mdi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic vld_reg;
    div_t dat_reg;
    div_t dat_next;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = dat_reg;

    // One restoring step for all nine lanes against the fixed shifted divisor.
    always_comb
    begin
        dat_next = in_data;
        for (int k = 0; k < 9; k++)
        begin
            logic [REM_W-1:0] r;
            logic             ge;
            r  = in_data.lane[k].rem;
            ge = (r >= {1'b0, in_data.dsh});
            if (ge) r = r - {1'b0, in_data.dsh};
            dat_next.lane[k].rem = {r[REM_W-2:0], 1'b0};
            dat_next.lane[k].quo = {in_data.lane[k].quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready) dat_reg <= dat_next;
    end

endmodule

// ===== rtl/core/mdi_sat.sv =====
module mdi_sat
    import mdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  div_t         in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [199:0] out_data,
    output logic [1:0]   out_user
);

    logic         vld_reg;
    logic [199:0] dat_reg;
    logic [1:0]   usr_reg;
    logic [199:0] dat_next;
    logic [1:0]   usr_next;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = dat_reg;
    assign out_user  = usr_reg;

    always_comb
    begin
        logic sat;
        sat      = 1'b0;
        dat_next = '0;
        for (int k = 0; k < 9; k++)
        begin
            logic [QUO_W-1:0] q;
            logic [QUO_W-1:0] v;
            q = in_data.lane[k].quo;
            if (in_data.lane[k].neg)
            begin
                if (in_data.lane[k].ovf || q > NEG_MAX)
                begin
                    v   = NEG_MAX;
                    sat = 1'b1;
                end
                else
                begin
                    v = -q;
                end
            end
            else
            begin
                if (in_data.lane[k].ovf || q > POS_MAX)
                begin
                    v   = POS_MAX;
                    sat = 1'b1;
                end
                else
                begin
                    v = q;
                end
            end
            if (in_data.sing) v = '0;
            dat_next[k*ELEM_W +: ELEM_W] = v;
        end
        dat_next[9*ELEM_W +: DET_W] = in_data.det;
        usr_next = {sat && !in_data.sing, in_data.sing};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            dat_reg <= dat_next;
            usr_reg <= usr_next;
        end
    end

endmodule

// ===== rtl/core/mdi_checker.sv =====
module mdi_checker
    import mdi_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // A singular matrix gives an all-zero inverse and no saturation.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[143:0] == '0 && !m_tuser[1])
        else $error("singular result with nonzero inverse");

    // The singular flag follows the determinant field exactly.
    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] == (m_tdata[192:144] == '0))
        else $error("singular flag disagrees with determinant");

    // Padding above the determinant stays zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[199:193] == '0)
        else $error("output padding not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

endmodule

bind matrix3_determinant_inverse mdi_checker u_mdi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_matrix3_determinant_inverse.sv =====
`timescale 1ns / 100ps

module tb_matrix3_determinant_inverse;

    import mdi_pkg::*;

    localparam int RANDOM_ITEMS = 1430;
    localparam int PAUSE_AT     = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [15:0] inv [9];
        logic signed [48:0] det;
        logic               sing;
        logic               sat;
    } inverse_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;

    logic [143:0] pending_mats [$];
    inverse_t     expected_invs [$];
    int           accepted = 0;
    int           received = 0;
    int           errors = 0;
    int           singular_seen = 0;
    int           saturated_seen = 0;
    int           cycles = 0;
    int           send_gap = 0;
    int           recv_stall = 0;

    matrix3_determinant_inverse uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic inverse_t invert_matrix(input logic [143:0] d);
        longint   m [9];
        longint   cof [9];
        longint   det;
        longint   q;
        inverse_t res;
        for (int k = 0; k < 9; k++)
        begin
            m[k] = longint'($signed(d[16*k +: 16]));
        end
        det = m[0]*m[4]*m[8] + m[3]*m[7]*m[2] + m[6]*m[1]*m[5]
            - m[6]*m[4]*m[2] - m[7]*m[5]*m[0] - m[8]*m[3]*m[1];
        cof[0] = m[4]*m[8] - m[5]*m[7];
        cof[1] = m[5]*m[6] - m[3]*m[8];
        cof[2] = m[3]*m[7] - m[4]*m[6];
        cof[3] = m[2]*m[7] - m[1]*m[8];
        cof[4] = m[0]*m[8] - m[2]*m[6];
        cof[5] = m[1]*m[6] - m[0]*m[7];
        cof[6] = m[1]*m[5] - m[2]*m[4];
        cof[7] = m[2]*m[3] - m[0]*m[5];
        cof[8] = m[0]*m[4] - m[1]*m[3];
        res.sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            q = 0;
            if (det != 0)
            begin
                // Adjugate entry (r, c) is cofactor (c, r); division truncates toward zero.
                q = (cof[(k % 3) * 3 + k / 3] * 65536) / det;
                if (q > 32767)
                begin
                    q = 32767;
                    res.sat = 1'b1;
                end
                if (q < -32768)
                begin
                    q = -32768;
                    res.sat = 1'b1;
                end
            end
            res.inv[k] = q[15:0];
        end
        res.det  = det[48:0];
        res.sing = (det == 0);
        return res;
    endfunction

    function automatic logic [143:0] pack_matrix(input int e [9]);
        logic [143:0] d;
        for (int k = 0; k < 9; k++)
        begin
            d[16*k +: 16] = e[k][15:0];
        end
        return d;
    endfunction

    function automatic logic [143:0] random_matrix();
        int           e [9];
        int           kind;
        logic [143:0] d;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            case (kind)
                0, 1, 2: e[k] = $signed(16'($urandom));
                3, 4, 5: e[k] = $urandom_range(0, 1024) - 512;
                6:       e[k] = $urandom_range(0, 16) - 8;
                default: e[k] = (k % 4 == 0) ? 256 + $urandom_range(0, 64) - 32
                                             : $urandom_range(0, 128) - 64;
            endcase
        end
        // Repeat a row now and then so the singular path stays busy.
        if (kind == 2 || kind == 5)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e[6 + c] = e[c];
            end
        end
        d = pack_matrix(e);
        return d;
    endfunction

    initial
    begin
        pending_mats.push_back(pack_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        pending_mats.push_back(pack_matrix('{256, 0, 0, 0, 256, 0, 0, 0, 256}));
        pending_mats.push_back(pack_matrix('{512, 0, 0, 0, 512, 0, 0, 0, 512}));
        pending_mats.push_back(pack_matrix('{32767, 32767, 32767, 32767, 32767,
                                            32767, 32767, 32767, 32767}));
        pending_mats.push_back(pack_matrix('{-32768, -32768, -32768, -32768, -32768,
                                            -32768, -32768, -32768, -32768}));
        pending_mats.push_back(pack_matrix('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
        pending_mats.push_back(pack_matrix('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}));
        pending_mats.push_back(pack_matrix('{-32768, 32767, 0, 32767, -32768, 32767,
                                            0, 32767, -32768}));
        pending_mats.push_back(pack_matrix('{32767, -32768, -32768, -32768, 32767,
                                            -32768, -32768, -32768, 32767}));
        pending_mats.push_back(pack_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
        pending_mats.push_back(pack_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1}));
        pending_mats.push_back(pack_matrix('{16, 0, 0, 0, 16, 0, 0, 0, -16}));
        pending_mats.push_back(pack_matrix('{0, 256, 0, 0, 0, 256, 256, 0, 0}));
        pending_mats.push_back(pack_matrix('{256, 512, 768, 512, 1024, 1536, 1, 2, 3}));
        pending_mats.push_back(pack_matrix('{256, 512, 768, 1024, 1280, 1536,
                                            1792, 2048, 2304}));
        pending_mats.push_back(pack_matrix('{512, 256, 0, 256, 512, 256, 0, 256, 512}));
        pending_mats.push_back(pack_matrix('{-256, 128, 64, 32, -512, 16, 8, 4, 768}));
        pending_mats.push_back(pack_matrix('{32767, 1, 0, 1, 32767, 0, 0, 0, 1}));
        pending_mats.push_back(pack_matrix('{100, 200, 300, -400, 500, -600, 700, 800, -900}));
        pending_mats.push_back(pack_matrix('{0, 0, 256, 0, 256, 0, 256, 0, 0}));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pending_mats.push_back(random_matrix());
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_mats.size() == 0 && !s_tvalid && expected_invs.size() == 0);
        repeat (40) @(posedge clk);
        $display("Checked %0d inverses of %0d matrices: %0d singular, %0d saturated.",
                 received, accepted, singular_seen, saturated_seen);
        if (errors == 0 && expected_invs.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Driver: one beat at a time from the pending queue, with a random gap after most.
    always @(posedge clk or negedge rst_n)
    begin
        logic         nxt_valid;
        logic [143:0] nxt_data;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready)
            begin
                expected_invs.push_back(invert_matrix(s_tdata));
                accepted++;
                nxt_valid = 1'b0;
                send_gap  = (accepted >= 600 && accepted < 800) ? 0 : $urandom_range(0, 5);
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_mats.size() > 0 &&
                         !(accepted == PAUSE_AT && expected_invs.size() > 0))
                begin
                    nxt_data  = pending_mats.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // Monitor: compares each output beat field by field with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        inverse_t exp_inv;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                received++;
                if (expected_invs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output beat %h", $time, m_tdata);
                end
                else
                begin
                    exp_inv = expected_invs.pop_front();
                    for (int k = 0; k < 9; k++)
                    begin
                        if (m_tdata[16*k +: 16] !== exp_inv.inv[k])
                        begin
                            errors++;
                            $display("%0t: inv_%0d expected %h actual %h", $time, k,
                                     exp_inv.inv[k], m_tdata[16*k +: 16]);
                        end
                    end
                    if (m_tdata[192:144] !== exp_inv.det)
                    begin
                        errors++;
                        $display("%0t: determinant expected %h actual %h", $time,
                                 exp_inv.det, m_tdata[192:144]);
                    end
                    if (m_tuser[0] !== exp_inv.sing)
                    begin
                        errors++;
                        $display("%0t: singular expected %b actual %b", $time,
                                 exp_inv.sing, m_tuser[0]);
                    end
                    if (m_tuser[1] !== exp_inv.sat)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_inv.sat, m_tuser[1]);
                    end
                    singular_seen  += exp_inv.sing;
                    saturated_seen += exp_inv.sat;
                end
                recv_stall = (received >= 900 && received < 1100) ? 0 : $urandom_range(0, 5);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_invs.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
